### hw/rtl/yuv422_to_bgra_converter_defines.svh
// Assertion macros shared by the yuv422_to_bgra_converter RTL.
// Expects a clock i_clk and an active-low synchronous reset i_rst_n in scope.
`ifndef YUV422_TO_BGRA_CONVERTER_DEFINES_SVH
`define YUV422_TO_BGRA_CONVERTER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define Y2B_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define Y2B_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/y2b_pkg.sv
// Types, constants and helpers of the YUV 4:2:2 to BGRA converter.
// No dependencies; used by every other file of the block but the defines header.
`timescale 1ns / 1ps

package y2b_pkg;

    localparam int WORD_W = 32;
    localparam int SMP_W  = 8;
    localparam int SUM_W  = 19;   // holds every product and channel sum

    typedef logic signed [SUM_W-1:0] t_sum;

    // BT.601 limited-range coefficients
    localparam t_sum K_Y_OFF = t_sum'(16);
    localparam t_sum K_C_OFF = t_sum'(128);
    localparam t_sum K_CY    = t_sum'(298);
    localparam t_sum K_RV    = t_sum'(409);
    localparam t_sum K_GU    = t_sum'(100);
    localparam t_sum K_GV    = t_sum'(208);
    localparam t_sum K_BU    = t_sum'(516);
    localparam t_sum K_RND   = t_sum'(128);
    localparam int   K_SHIFT = 8;
    localparam logic [SMP_W-1:0] K_ALPHA   = 8'hFF;
    localparam logic [SMP_W-1:0] K_CH_MAX  = 8'hFF;

    typedef enum logic {
        ORDER_YUYV = 1'b0,
        ORDER_UYVY = 1'b1
    } t_pack_order;

    typedef struct packed {
        logic [SMP_W-1:0] y0;
        logic [SMP_W-1:0] y1;
        logic [SMP_W-1:0] u;
        logic [SMP_W-1:0] v;
    } t_yuv;

    typedef struct packed {
        t_sum c0;
        t_sum c1;
        t_sum rv;
        t_sum gu;
        t_sum gv;
        t_sum bu;
    } t_prod;

    typedef struct packed {
        t_sum r0;
        t_sum g0;
        t_sum b0;
        t_sum r1;
        t_sum g1;
        t_sum b1;
    } t_chan;

    // Floor shift by 8, then clamp to 0..255.
    function automatic logic [SMP_W-1:0] clamp8(input t_sum sum);
        t_sum q;
        q = sum >>> K_SHIFT;
        if (q < 0) begin
            return '0;
        end else if (q > t_sum'(K_CH_MAX)) begin
            return K_CH_MAX;
        end else begin
            return q[SMP_W-1:0];
        end
    endfunction

endpackage

### hw/rtl/y2b_stream_if.sv
// Valid/ready stream interfaces for packed 4:2:2 words and BGRA pixel pairs.
// Depends on y2b_pkg for field widths.
`timescale 1ns / 1ps

interface y2b_in_if;
    logic                        valid;
    logic                        ready;
    logic [y2b_pkg::WORD_W-1:0]  packed_word;

    modport source (output valid, output packed_word, input ready);
    modport sink   (input valid, input packed_word, output ready);
endinterface

interface y2b_out_if;
    logic                        valid;
    logic                        ready;
    logic [y2b_pkg::WORD_W-1:0]  first_pixel;
    logic [y2b_pkg::WORD_W-1:0]  second_pixel;

    modport source (output valid, output first_pixel, output second_pixel, input ready);
    modport sink   (input valid, input first_pixel, input second_pixel, output ready);
endinterface

### hw/rtl/y2b_unpack.sv
// Stage 1: splits a packed 4:2:2 word into Y0, Y1, U, V by byte order.
// Depends on y2b_pkg.
`timescale 1ns / 1ps

module y2b_unpack (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  y2b_pkg::t_pack_order       i_pack_order,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [y2b_pkg::WORD_W-1:0] i_word,
    output logic                       o_valid,
    input  logic                       i_ready,
    output y2b_pkg::t_yuv              o_yuv
);

    logic          r_valid;
    y2b_pkg::t_yuv r_yuv;
    y2b_pkg::t_yuv n_yuv;

    always_comb begin
        unique case (i_pack_order)
            y2b_pkg::ORDER_UYVY: begin
                n_yuv.u  = i_word[7:0];
                n_yuv.y0 = i_word[15:8];
                n_yuv.v  = i_word[23:16];
                n_yuv.y1 = i_word[31:24];
            end
            default: begin
                n_yuv.y0 = i_word[7:0];
                n_yuv.u  = i_word[15:8];
                n_yuv.y1 = i_word[23:16];
                n_yuv.v  = i_word[31:24];
            end
        endcase
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_yuv <= n_yuv;
        end
    end

    assign o_valid = r_valid;
    assign o_yuv   = r_yuv;

endmodule

### hw/rtl/y2b_mult.sv
// Stage 2: removes offsets and forms the six constant products.
// Depends on y2b_pkg.
`timescale 1ns / 1ps

module y2b_mult (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  y2b_pkg::t_yuv  i_yuv,
    output logic           o_valid,
    input  logic           i_ready,
    output y2b_pkg::t_prod o_prod
);

    logic           r_valid;
    y2b_pkg::t_prod r_prod;
    y2b_pkg::t_prod n_prod;
    y2b_pkg::t_sum  y0_off;
    y2b_pkg::t_sum  y1_off;
    y2b_pkg::t_sum  d;
    y2b_pkg::t_sum  e;

    always_comb begin
        y0_off = y2b_pkg::t_sum'(i_yuv.y0) - y2b_pkg::K_Y_OFF;
        y1_off = y2b_pkg::t_sum'(i_yuv.y1) - y2b_pkg::K_Y_OFF;
        d      = y2b_pkg::t_sum'(i_yuv.u) - y2b_pkg::K_C_OFF;
        e      = y2b_pkg::t_sum'(i_yuv.v) - y2b_pkg::K_C_OFF;
        n_prod.c0 = y0_off * y2b_pkg::K_CY;
        n_prod.c1 = y1_off * y2b_pkg::K_CY;
        n_prod.rv = e * y2b_pkg::K_RV;
        n_prod.gu = d * y2b_pkg::K_GU;
        n_prod.gv = e * y2b_pkg::K_GV;
        n_prod.bu = d * y2b_pkg::K_BU;
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_prod <= n_prod;
        end
    end

    assign o_valid = r_valid;
    assign o_prod  = r_prod;

endmodule

### hw/rtl/y2b_pack.sv
// Stages 3 and 4: channel sums with rounding, then shift, clamp and BGRA pack.
// Depends on y2b_pkg.
`timescale 1ns / 1ps

module y2b_pack (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  y2b_pkg::t_prod             i_prod,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [y2b_pkg::WORD_W-1:0] o_first_pixel,
    output logic [y2b_pkg::WORD_W-1:0] o_second_pixel
);

    logic                       r_sum_valid;
    y2b_pkg::t_chan             r_chan;
    y2b_pkg::t_chan             n_chan;
    logic                       sum_ready;
    logic                       r_pix_valid;
    logic [y2b_pkg::WORD_W-1:0] r_first;
    logic [y2b_pkg::WORD_W-1:0] r_second;
    logic [y2b_pkg::WORD_W-1:0] n_first;
    logic [y2b_pkg::WORD_W-1:0] n_second;

    // stage 3: sums
    always_comb begin
        n_chan.r0 = i_prod.c0 + i_prod.rv + y2b_pkg::K_RND;
        n_chan.g0 = i_prod.c0 - i_prod.gu - i_prod.gv + y2b_pkg::K_RND;
        n_chan.b0 = i_prod.c0 + i_prod.bu + y2b_pkg::K_RND;
        n_chan.r1 = i_prod.c1 + i_prod.rv + y2b_pkg::K_RND;
        n_chan.g1 = i_prod.c1 - i_prod.gu - i_prod.gv + y2b_pkg::K_RND;
        n_chan.b1 = i_prod.c1 + i_prod.bu + y2b_pkg::K_RND;
    end

    assign o_ready = !r_sum_valid || sum_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_valid <= 1'b0;
        end else if (o_ready) begin
            r_sum_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_chan <= n_chan;
        end
    end

    // stage 4: clamp and pack, this is the output register
    always_comb begin
        n_first  = {y2b_pkg::K_ALPHA, y2b_pkg::clamp8(r_chan.r0),
                    y2b_pkg::clamp8(r_chan.g0), y2b_pkg::clamp8(r_chan.b0)};
        n_second = {y2b_pkg::K_ALPHA, y2b_pkg::clamp8(r_chan.r1),
                    y2b_pkg::clamp8(r_chan.g1), y2b_pkg::clamp8(r_chan.b1)};
    end

    assign sum_ready = !r_pix_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pix_valid <= 1'b0;
        end else if (sum_ready) begin
            r_pix_valid <= r_sum_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (sum_ready && r_sum_valid) begin
            r_first  <= n_first;
            r_second <= n_second;
        end
    end

    assign o_valid        = r_pix_valid;
    assign o_first_pixel  = r_first;
    assign o_second_pixel = r_second;

endmodule

### hw/rtl/yuv422_to_bgra_converter.sv
// YUV 4:2:2 to BGRA converter, 4-stage pipeline; uses y2b_pkg, the interfaces, stage modules.
// Result path: an accepted word passes 4 register stages (unpack, products, sums, pixels) to o_out.
// Throughput: a word in, a pixel pair out per cycle if o_out is ready; stages reload as requests leave.
// Stalls: a full stage holds its request while the next is blocked; empty stages still fill.
// Reset (i_rst_n low, synchronous) empties the pipeline and selects YUYV order.
`timescale 1ns / 1ps
`include "yuv422_to_bgra_converter_defines.svh"

module yuv422_to_bgra_converter (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,     // pack order write strobe
    input  logic             i_cfg_wdata,  // 0 = YUYV, 1 = UYVY
    y2b_in_if.sink           i_in,
    y2b_out_if.source        o_out
);

    // Config register; the user must change it only while the pipe is empty; the block does not enforce this.
    y2b_pkg::t_pack_order r_pack_order;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pack_order <= y2b_pkg::ORDER_YUYV;
        end else if (i_cfg_we) begin
            r_pack_order <= y2b_pkg::t_pack_order'(i_cfg_wdata);
        end
    end

    // Stage links. Each stage loads when it is empty or its consumer takes
    // its current request, so a full pipe still moves one request a cycle while o_out.ready is high.
    logic           s1_valid;
    logic           s1_ready;
    y2b_pkg::t_yuv  s1_yuv;
    logic           s2_valid;
    logic           s2_ready;
    y2b_pkg::t_prod s2_prod;

    // Stage 1: byte-order decode into Y0, Y1, U, V
    y2b_unpack u_unpack (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pack_order (r_pack_order),
        .i_valid      (i_in.valid),
        .o_ready      (i_in.ready),
        .i_word       (i_in.packed_word),
        .o_valid      (s1_valid),
        .i_ready      (s1_ready),
        .o_yuv        (s1_yuv)
    );

    // Stage 2: offset removal and the 298/409/100/208/516 products
    y2b_mult u_mult (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s1_valid),
        .o_ready (s1_ready),
        .i_yuv   (s1_yuv),
        .o_valid (s2_valid),
        .i_ready (s2_ready),
        .o_prod  (s2_prod)
    );

    // Stages 3 and 4: rounding sums, floor shift, clamp, BGRA pack.
    // Stage 4 is the output register feeding o_out.
    y2b_pack u_pack (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (s2_valid),
        .o_ready        (s2_ready),
        .i_prod         (s2_prod),
        .o_valid        (o_out.valid),
        .i_ready        (o_out.ready),
        .o_first_pixel  (o_out.first_pixel),
        .o_second_pixel (o_out.second_pixel)
    );

    // An accepted request always lands in stage 1.
    `Y2B_ASSERT_NEXT(a_in_lands, i_in.valid && i_in.ready, s1_valid,
        "request lost at stage 1")

    // A stalled stage 1 keeps its request.
    `Y2B_ASSERT_NEXT(a_s1_hold, s1_valid && !s1_ready, s1_valid && $stable(s1_yuv),
        "stage 1 dropped data")

    // A stalled stage 2 keeps its products.
    `Y2B_ASSERT_NEXT(a_s2_hold, s2_valid && !s2_ready, s2_valid && $stable(s2_prod),
        "stage 2 dropped data")

    // Alpha is opaque on both pixels.
    `Y2B_ASSERT_NOW(a_alpha, o_out.valid,
        (o_out.first_pixel[31:24] == y2b_pkg::K_ALPHA) &&
        (o_out.second_pixel[31:24] == y2b_pkg::K_ALPHA),
        "alpha not opaque")

endmodule

### verif/yuv422_to_bgra_converter_tb.sv
// Self-checking testbench for yuv422_to_bgra_converter: directed table, then random requests.
// Depends on y2b_pkg, the y2b stream interfaces and the converter RTL.
`timescale 1ns / 1ps

module yuv422_to_bgra_converter_tb;
    import y2b_pkg::*;

    localparam int CLK_HALF_NS  = 4;
    localparam int RESET_CYCLES = 6;
    localparam int STALL_LIMIT  = 2000;  // cycles with no handshake on either side
    localparam int SETTLE_CYCLES = 8;    // pipeline is 4 deep; leave margin for strays
    localparam int SEG_ITEMS    = 200;   // random requests per byte-order segment

    // One expected pixel pair.
    typedef struct packed {
        logic [WORD_W-1:0] first_pixel;
        logic [WORD_W-1:0] second_pixel;
    } t_pixel_pair;

    // Typed-in result for a table row; pinned = 0 leaves it to the predictor.
    typedef struct packed {
        logic        pinned;
        t_pixel_pair pair;
    } t_pinned_pair;

    typedef struct packed {
        t_pack_order  order;
        logic [31:0]  word;
        t_pinned_pair expected;
    } t_stim_row;

    localparam t_pixel_pair BLACK_WHITE = '{32'hFF00_0000, 32'hFFFF_FFFF};
    localparam t_pinned_pair PREDICT    = '{1'b0, '0};
    localparam t_pinned_pair BW_PINNED  = '{1'b1, BLACK_WHITE};

    // Directed rows. The pinned ones are nominal black (Y=16 or below) on the left
    // and nominal white (Y=235 or above) on the right, with neutral chroma 0x80.
    localparam int N_ROWS = 20;
    localparam t_stim_row DIRECTED_ROWS [N_ROWS] = '{
        '{ORDER_YUYV, 32'h80EB_8010, BW_PINNED},  // Y0=16 Y1=235 neutral chroma
        '{ORDER_YUYV, 32'h80FF_8000, BW_PINNED},  // Y extremes 0 and 255
        '{ORDER_YUYV, 32'h0000_0000, PREDICT},
        '{ORDER_YUYV, 32'hFFFF_FFFF, PREDICT},
        '{ORDER_YUYV, 32'hF0EB_1010, PREDICT},    // U low, V high
        '{ORDER_YUYV, 32'h10EB_F010, PREDICT},    // U high, V low
        '{ORDER_YUYV, 32'h8080_8080, PREDICT},
        '{ORDER_YUYV, 32'hFF00_FF00, PREDICT},
        '{ORDER_YUYV, 32'h00FF_00FF, PREDICT},
        '{ORDER_YUYV, 32'hAAAA_5555, PREDICT},
        '{ORDER_UYVY, 32'hEB80_1080, BW_PINNED},  // same pixels as the first row
        '{ORDER_UYVY, 32'hFF80_0080, BW_PINNED},
        '{ORDER_UYVY, 32'h0000_0000, PREDICT},
        '{ORDER_UYVY, 32'hFFFF_FFFF, PREDICT},
        '{ORDER_UYVY, 32'hEBF0_1010, PREDICT},
        '{ORDER_UYVY, 32'h10EB_10F0, PREDICT},
        '{ORDER_UYVY, 32'h80EB_8010, PREDICT},    // a YUYV word read as UYVY
        '{ORDER_UYVY, 32'h55AA_55AA, PREDICT},
        '{ORDER_YUYV, 32'hEB80_1080, PREDICT},    // a UYVY word read as YUYV
        '{ORDER_YUYV, 32'h807F_8081, PREDICT}
    };

    // Byte order per random segment, two segments per idling phase.
    localparam t_pack_order SEG_ORDER [6] = '{
        ORDER_UYVY, ORDER_YUYV, ORDER_UYVY, ORDER_UYVY, ORDER_YUYV, ORDER_UYVY
    };

    logic i_clk;
    logic i_rst_n;
    logic cfg_we;
    logic cfg_wdata;

    y2b_in_if  in_if ();
    y2b_out_if out_if ();

    yuv422_to_bgra_converter dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    // Shadow of the byte order register; only changes while the pipe is empty.
    t_pack_order  pack_order;
    t_pixel_pair  pending_pairs [$];   // expected results in request order
    t_pinned_pair pinned_pixels [$];   // typed-in results of the request being offered
    int           error_count;
    int           stall_cycles;
    int           src_idle_pct;
    int           snk_idle_pct;

    always #(CLK_HALF_NS) i_clk = ~i_clk;

    // ---------------------------------------------------------------------
    // Predictor: BT.601 limited-range integer conversion.
    // ---------------------------------------------------------------------

    // Floor shift by 8, then saturate to one byte.
    function automatic logic [7:0] sat_channel(input int sum);
        int q;
        q = sum >>> 8;
        if (q < 0) begin
            return 8'd0;
        end else if (q > 255) begin
            return 8'd255;
        end
        return q[7:0];
    endfunction

    function automatic logic [31:0] bgra_of(input logic [7:0] y, input logic [7:0] u,
                                            input logic [7:0] v);
        int c;
        int d;
        int e;
        c = 298 * (int'(y) - 16);
        d = int'(u) - 128;
        e = int'(v) - 128;
        return {8'hFF,
                sat_channel(c + 409 * e + 128),
                sat_channel(c - 100 * d - 208 * e + 128),
                sat_channel(c + 516 * d + 128)};
    endfunction

    // Both pixels share U and V; the byte order decides where each sample sits.
    function automatic t_pixel_pair convert_word(input logic [31:0] word,
                                                 input t_pack_order order);
        logic [7:0] y0;
        logic [7:0] y1;
        logic [7:0] u;
        logic [7:0] v;
        if (order == ORDER_UYVY) begin
            {y1, v, y0, u} = word;
        end else begin
            {v, y1, u, y0} = word;
        end
        return '{bgra_of(y0, u, v), bgra_of(y1, u, v)};
    endfunction

    // ---------------------------------------------------------------------
    // Random stimulus
    // ---------------------------------------------------------------------

    // Samples lean on the clamp edges and the nominal range limits.
    function automatic logic [7:0] pick_sample();
        logic [7:0] corners [13];
        corners = '{8'd0, 8'd1, 8'd15, 8'd16, 8'd17, 8'd127, 8'd128,
                    8'd129, 8'd235, 8'd236, 8'd240, 8'd241, 8'd255};
        case ($urandom_range(3))
            0: return corners[$urandom_range(12)];
            1: return 8'($urandom_range(240, 16));
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [31:0] random_word();
        if ($urandom_range(2) == 0) begin
            return $urandom;
        end
        return {pick_sample(), pick_sample(), pick_sample(), pick_sample()};
    endfunction

    // ---------------------------------------------------------------------
    // Driver tasks (all called from the main sequence, at a rising edge)
    // ---------------------------------------------------------------------

    // Offer one request after a random gap and hold it until accepted.
    task automatic send_word(input logic [31:0] word, input t_pinned_pair expected);
        while ($urandom_range(99) < src_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        pinned_pixels.push_back(expected);
        in_if.valid       <= 1'b1;
        in_if.packed_word <= word;
        @(posedge i_clk);
        while (!in_if.ready) begin
            @(posedge i_clk);
        end
    endtask

    // Stop sending, let every result drain, then write the byte order register.
    task automatic set_order(input t_pack_order order);
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_pairs.size() != 0) begin
            @(posedge i_clk);
        end
        cfg_we    <= 1'b1;
        cfg_wdata <= order;
        @(posedge i_clk);
        cfg_we     <= 1'b0;
        pack_order  = order;
    endtask

    // ---------------------------------------------------------------------
    // Receiver: ready drops at random per the current idling rate.
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin
        out_if.ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    // ---------------------------------------------------------------------
    // Scoreboard: record on input handshake, compare on output handshake.
    // Pushes come before pops so a result leaving in the same cycle as its request would still match.
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_pixel_pair  want;
        t_pinned_pair pin;
        if (i_rst_n) begin
            if (in_if.valid && in_if.ready) begin
                pin = pinned_pixels.pop_front();
                if (pin.pinned) begin
                    pending_pairs.push_back(pin.pair);
                end else begin
                    pending_pairs.push_back(convert_word(in_if.packed_word, pack_order));
                end
            end
            if (out_if.valid && out_if.ready) begin
                if (pending_pairs.size() == 0) begin
                    $error("unexpected result: first_pixel %h, second_pixel %h",
                           out_if.first_pixel, out_if.second_pixel);
                    error_count++;
                end else begin
                    want = pending_pairs.pop_front();
                    if (out_if.first_pixel !== want.first_pixel) begin
                        $error("first_pixel mismatch: expected %h, actual %h",
                               want.first_pixel, out_if.first_pixel);
                        error_count++;
                    end
                    if (out_if.second_pixel !== want.second_pixel) begin
                        $error("second_pixel mismatch: expected %h, actual %h",
                               want.second_pixel, out_if.second_pixel);
                        error_count++;
                    end
                end
            end
            // Watchdog: any handshake on either side counts as progress.
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------------
    initial begin
        i_clk             = 1'b0;
        i_rst_n           = 1'b0;
        cfg_we            = 1'b0;
        cfg_wdata         = ORDER_YUYV;
        in_if.valid       = 1'b0;
        in_if.packed_word = '0;
        out_if.ready      = 1'b0;
        pack_order        = ORDER_YUYV;
        error_count       = 0;
        stall_cycles      = 0;
        src_idle_pct      = 34;
        snk_idle_pct      = 70;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table. Row 0 runs on the reset order; the register is
        // rewritten whenever a row asks for a different order.
        for (int row = 0; row < N_ROWS; row++) begin
            if (row > 0 && DIRECTED_ROWS[row].order != pack_order) begin
                set_order(DIRECTED_ROWS[row].order);
            end
            send_word(DIRECTED_ROWS[row].word, DIRECTED_ROWS[row].expected);
        end

        // Random requests: receiver-heavy idling, sender-heavy idling, then none.
        // Each phase drains and rewrites the register before each of its two segments.
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    src_idle_pct = 34;
                    snk_idle_pct = 70;
                end
                1: begin
                    src_idle_pct = 70;
                    snk_idle_pct = 34;
                end
                default: begin
                    src_idle_pct = 0;
                    snk_idle_pct = 0;
                end
            endcase
            for (int seg = 0; seg < 2; seg++) begin
                set_order(SEG_ORDER[2 * phase + seg]);
                repeat (SEG_ITEMS) begin
                    send_word(random_word(), PREDICT);
                end
            end
        end

        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_pairs.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
